FILE: design/tsm_pkg.sv
// ----------------------------------------------------------------------------
// tsm_pkg: shared types and constants of the trip speeding monitor.
// Holds the payload structures, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none
package tsm_pkg;

    // Register indexes of the configuration port.
    localparam int unsigned CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] REG_SPEED_MARGIN = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_MIN_OVER_MS  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_ROUTE_INT    = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_JUMP_MIN     = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_JUMP_MAXSPD  = 3'd4;
    localparam int unsigned CfgDataW = 20;

    // Reset values of the registers.
    localparam logic [15:0] RST_SPEED_MARGIN = 16'd500;
    localparam logic [19:0] RST_MIN_OVER_MS  = 20'd3000;
    localparam logic [11:0] RST_ROUTE_INT    = 12'd5;
    localparam logic [19:0] RST_JUMP_MIN     = 20'd1600;
    localparam logic [15:0] RST_JUMP_MAXSPD  = 16'd25000;

    // Width of one serial digit of the jump products; the default for the top.
    localparam int unsigned DIGIT_W = 4;

    // Scale factor of the jump test: speed ratio 22.5 squared times four.
    localparam logic [11:0] JUMP_K = 12'd2025;

    typedef struct packed {
        logic [15:0]        speed;
        logic [15:0]        speed_limit;
        logic               position_known;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_z;
        logic               trip_active;
        logic [31:0]        wall_seconds;
        logic [31:0]        steady_ms;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        top_speed;
        logic [15:0]        jump_count;
        logic               speeding_active;
        logic               point_taken;
        logic               stretch_closed;
        logic [15:0]        stretch_peak;
        logic [15:0]        stretch_limit;
        logic [31:0]        stretch_start;
        logic [31:0]        stretch_end;
        logic signed [31:0] stretch_x;
        logic signed [31:0] stretch_z;
    } t_out_item;

endpackage
`default_nettype wire

FILE: design/trip_speeding_monitor.sv
// Flow from the accepting edge to a valid result: an item that takes a route point
// after a known point with a positive time step runs the jump test through a digit-serial
// multiplier: prepare, three serial products, compare, output. Any other item skips the
// serial products. One item is in work at a time, and the next item is taken the cycle
// after the result is accepted; the serial multiplier sets the rate.
// Synchronous active-low reset restores register defaults and clears the trip.
// ----------------------------------------------------------------------------
// trip_speeding_monitor: per-sample trip supervisor.
// Tracks top speed, route points, teleport jumps and speeding stretches.
// ----------------------------------------------------------------------------
`default_nettype none
module trip_speeding_monitor #(
    parameter int unsigned DigitW = tsm_pkg::DIGIT_W
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire tsm_pkg::t_in_item              i_in_item,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output tsm_pkg::t_out_item                  o_out_item,
    input  wire logic                           i_cfg_we,
    input  wire logic [tsm_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  wire logic [tsm_pkg::CfgDataW-1:0]   i_cfg_data
);

    // Multiplier operand width: operands are 64 bits, the accumulator 129.
    localparam int unsigned OpW    = 64;
    localparam int unsigned Digits = OpW / DigitW;
    localparam int unsigned CntW   = $clog2(Digits + 1);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_PREP = 7'b0000010,
        ST_DX   = 7'b0000100,
        ST_DZ   = 7'b0001000,
        ST_RHS  = 7'b0010000,
        ST_CMP  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [15:0] r_margin;
    logic [19:0] r_min_over;
    logic [11:0] r_route_int;
    logic [19:0] r_jump_min;
    logic [15:0] r_jump_max;

    // Trip state.
    logic        r_trip_was_on, r_point_known, r_over_armed, r_in_stretch;
    logic [15:0] r_peak, r_jumps, r_open_peak, r_open_limit;
    logic [31:0] r_point_time, r_point_x, r_point_z, r_over_since, r_open_start;
    logic [31:0] r_open_x, r_open_z;

    tsm_pkg::t_in_item  r_item;
    tsm_pkg::t_out_item r_out;
    logic               r_out_valid;

    // Per-item flags decided in the prepare step.
    logic        r_taken, r_do_jump;
    logic [32:0] r_dt;

    // Serial multiplier: multiplicand, shifting multiplier, accumulator.
    logic [OpW-1:0]   r_mcand, r_mplier;
    logic [2*OpW:0]   r_acc;
    logic [CntW-1:0]  r_cnt;
    logic [2*OpW:0]   r_d2;
    logic [2*OpW+11:0] r_lhs;
    logic [2*OpW+11:0] r_rhs;
    logic             r_dmin_ok;

    // Combinational helpers.
    logic        w_in_fire, w_out_fire;
    logic [32:0] w_dt;
    logic [32:0] w_dx, w_dz;
    logic [31:0] w_ax, w_az;
    logic [DigitW+OpW-1:0] w_pp;
    logic [2*OpW+DigitW-1:0] w_acc_sum;
    logic [2*OpW:0] w_acc_next;
    logic [39:0] w_dmin;
    logic [33:0] w_js;
    logic [2*OpW+11:0] w_lhs;

    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_fire = r_out_valid && i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Time step and position differences against the stored route point.
    assign w_dt = {1'b0, r_item.wall_seconds} - {1'b0, r_point_time};
    assign w_dx = {r_item.pos_x[31], r_item.pos_x} - {r_point_x[31], r_point_x};
    assign w_dz = {r_item.pos_z[31], r_item.pos_z} - {r_point_z[31], r_point_z};
    assign w_ax = w_dx[32] ? 32'(-w_dx) : w_dx[31:0];
    assign w_az = w_dz[32] ? 32'(-w_dz) : w_dz[31:0];

    // One digit of the multiplier per cycle; the partial sum shifts right.
    assign w_pp = r_mcand * r_mplier[DigitW-1:0];
    assign w_acc_sum  = (2*OpW+DigitW)'(r_acc) + ((2*OpW+DigitW)'(w_pp) << OpW);
    assign w_acc_next = (2*OpW+1)'(w_acc_sum >> DigitW);
    assign w_dmin = 40'(r_jump_min) * 40'(r_jump_min);
    assign w_js   = {32'(r_jump_max) * 32'(r_jump_max), 2'b00};
    assign w_lhs  = (2*OpW+12)'(r_d2) * (2*OpW+12)'(tsm_pkg::JUMP_K);

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_in_fire) n_state = ST_PREP;
            ST_PREP: n_state = ST_DX;
            ST_DX:   if (!r_do_jump) n_state = ST_CMP;
                     else if (r_cnt == CntW'(Digits)) n_state = ST_DZ;
            ST_DZ:   if (r_cnt == CntW'(Digits)) n_state = ST_RHS;
            ST_RHS:  if (r_cnt == CntW'(Digits)) n_state = ST_CMP;
            ST_CMP:  n_state = ST_OUT;
            ST_OUT:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin    <= tsm_pkg::RST_SPEED_MARGIN;
            r_min_over  <= tsm_pkg::RST_MIN_OVER_MS;
            r_route_int <= tsm_pkg::RST_ROUTE_INT;
            r_jump_min  <= tsm_pkg::RST_JUMP_MIN;
            r_jump_max  <= tsm_pkg::RST_JUMP_MAXSPD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tsm_pkg::REG_SPEED_MARGIN: r_margin    <= i_cfg_data[15:0];
                tsm_pkg::REG_MIN_OVER_MS:  r_min_over  <= i_cfg_data[19:0];
                tsm_pkg::REG_ROUTE_INT:    r_route_int <= i_cfg_data[11:0];
                tsm_pkg::REG_JUMP_MIN:     r_jump_min  <= i_cfg_data[19:0];
                tsm_pkg::REG_JUMP_MAXSPD:  r_jump_max  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) r_item <= i_in_item;
        unique case (r_state)
            ST_PREP: begin
                r_dt      <= w_dt;
                r_mcand   <= 64'(w_ax);
                r_mplier  <= 64'(w_ax);
                r_acc     <= '0;
                r_cnt     <= '0;
                r_dmin_ok <= 1'b0;
            end
            ST_DX, ST_DZ, ST_RHS: begin
                if (r_cnt == CntW'(Digits)) begin
                    r_cnt <= '0;
                    if (r_state == ST_DX) begin
                        r_d2     <= r_acc;
                        r_acc    <= '0;
                        r_mcand  <= 64'(w_az);
                        r_mplier <= 64'(w_az);
                    end else if (r_state == ST_DZ) begin
                        r_d2      <= r_d2 + r_acc;
                        r_acc     <= '0;
                        r_mcand   <= 64'(r_dt[31:0]) * 64'(r_dt[31:0]);
                        r_mplier  <= 64'(w_js);
                    end else begin
                        r_rhs <= (2*OpW+12)'(r_acc);
                    end
                end else begin
                    r_cnt    <= r_cnt + 1'b1;
                    r_acc    <= w_acc_next;
                    r_mplier <= r_mplier >> DigitW;
                end
            end
            ST_CMP: begin
                r_dmin_ok <= r_d2 > (2*OpW+1)'(w_dmin);
                r_lhs     <= w_lhs;
            end
            default: ;
        endcase
    end

    // Trip state and result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_out_valid   <= 1'b0;
            r_trip_was_on <= 1'b0;
            r_peak <= '0; r_jumps <= '0; r_point_known <= 1'b0;
            r_point_time <= '0; r_point_x <= '0; r_point_z <= '0;
            r_over_armed <= 1'b0; r_over_since <= '0; r_in_stretch <= 1'b0;
            r_open_start <= '0; r_open_peak <= '0; r_open_limit <= '0;
            r_open_x <= '0; r_open_z <= '0;
            r_taken <= 1'b0; r_do_jump <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_fire) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_PREP: begin
                    logic trip_start, pt_known;
                    // Rising trip edge clears the trip before anything else.
                    trip_start = r_item.trip_active && !r_trip_was_on;
                    pt_known   = r_point_known && !trip_start;
                    r_trip_was_on <= r_item.trip_active;
                    r_taken   <= 1'b0;
                    r_do_jump <= 1'b0;
                    if (trip_start) begin
                        r_peak <= '0; r_jumps <= '0; r_point_known <= 1'b0;
                        r_point_time <= '0; r_point_x <= '0; r_point_z <= '0;
                        r_over_armed <= 1'b0; r_over_since <= '0;
                        r_in_stretch <= 1'b0; r_open_start <= '0;
                        r_open_peak <= '0; r_open_limit <= '0;
                        r_open_x <= '0; r_open_z <= '0;
                    end
                    // Route point decision, seen through the cleared state.
                    if (r_item.trip_active && r_item.position_known && (!pt_known ||
                        (!w_dt[32] && w_dt[31:0] >= 32'(r_route_int)))) begin
                        r_taken <= 1'b1;
                        if (pt_known && !w_dt[32] && w_dt[31:0] != '0)
                            r_do_jump <= 1'b1;
                    end
                end
                ST_OUT: begin
                    logic [16:0] thr;
                    logic        over, closed, in_s;
                    logic [15:0] pk, opk, olim;
                    logic [31:0] ost, ox, oz;
                    logic [15:0] jmp;
                    thr    = 17'(r_item.speed_limit) + 17'(r_margin);
                    over   = r_item.speed_limit != '0 && 17'(r_item.speed) > thr;
                    closed = 1'b0;
                    in_s   = r_in_stretch;
                    pk     = r_peak; opk = r_open_peak; olim = r_open_limit;
                    ost    = r_open_start; ox = r_open_x; oz = r_open_z;
                    jmp    = r_jumps;
                    if (r_item.trip_active) begin
                        if (r_item.speed > pk) pk = r_item.speed;
                        if (r_do_jump && r_dmin_ok && r_lhs > r_rhs && jmp != 16'hFFFF)
                            jmp = jmp + 1'b1;
                        if (r_taken) begin
                            r_point_time  <= r_item.wall_seconds;
                            r_point_x     <= r_item.pos_x;
                            r_point_z     <= r_item.pos_z;
                            r_point_known <= 1'b1;
                        end
                        if (over) begin
                            logic [31:0] since;
                            since = r_over_armed ? r_over_since : r_item.steady_ms;
                            r_over_armed <= 1'b1;
                            r_over_since <= since;
                            if (!in_s && (r_item.steady_ms - since) >= 32'(r_min_over)) begin
                                in_s = 1'b1;
                                ost  = r_item.wall_seconds;
                                opk  = r_item.speed;
                                olim = r_item.speed_limit;
                                ox   = r_item.position_known ? r_item.pos_x : '0;
                                oz   = r_item.position_known ? r_item.pos_z : '0;
                            end
                            if (in_s && r_item.speed > opk) opk = r_item.speed;
                        end else begin
                            r_over_armed <= 1'b0;
                            if (in_s) begin
                                in_s   = 1'b0;
                                closed = 1'b1;
                            end
                        end
                    end
                    r_peak <= pk; r_jumps <= jmp; r_in_stretch <= in_s;
                    r_open_peak <= opk; r_open_limit <= olim; r_open_start <= ost;
                    r_open_x <= ox; r_open_z <= oz;
                    r_out.top_speed       <= pk;
                    r_out.jump_count      <= jmp;
                    r_out.speeding_active <= in_s;
                    r_out.point_taken     <= r_taken && r_item.trip_active;
                    r_out.stretch_closed  <= closed;
                    r_out.stretch_peak    <= opk;
                    r_out.stretch_limit   <= olim;
                    r_out.stretch_start   <= ost;
                    r_out.stretch_end     <= closed ? r_item.wall_seconds : '0;
                    r_out.stretch_x       <= ox;
                    r_out.stretch_z       <= oz;
                    r_out_valid           <= 1'b1;
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: design/tsm_checker.sv
// ----------------------------------------------------------------------------
// tsm_checker: port-level checks of the trip speeding monitor.
// Watches the handshakes and the result fields over time.
// ----------------------------------------------------------------------------
`default_nettype none
module tsm_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire tsm_pkg::t_out_item o_out_item
);

    // A result that waits keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // No new item is taken while a result waits.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while result pending");

    // Once an item is taken the input closes while it is in work.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after an accepted item");

    // A stretch end time is only shown when a stretch closes.
    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.stretch_closed |-> o_out_item.stretch_end == '0)
        else $error("stretch end without close");

    // A closed stretch is no longer active.
    a_close_inactive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.stretch_closed |-> !o_out_item.speeding_active)
        else $error("closed stretch still active");

endmodule

bind trip_speeding_monitor tsm_checker u_tsm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
`default_nettype wire

FILE: verif/trip_speeding_monitor_checker.sv
// ----------------------------------------------------------------------------
// trip_speeding_monitor_checker: result predictor and scoreboard.
// Watches the configuration port and both item channels. Each accepted input
// item is run through a local model of the trip supervisor, and each accepted
// result is compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module trip_speeding_monitor_checker
    import tsm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  t_in_item                 i_in_item,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  t_out_item                i_out_item,
    input  logic                     i_cfg_we,
    input  logic [CfgIdxW-1:0]       i_cfg_index,
    input  logic [CfgDataW-1:0]      i_cfg_data,
    output int                       o_errors,
    output int                       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Local copy of the registers.
    logic [15:0] margin_q;
    logic [19:0] min_over_q;
    logic [11:0] interval_q;
    logic [19:0] jump_min_q;
    logic [15:0] jump_spd_q;

    // Local copy of the trip state.
    logic               trip_on_q, pt_known_q, armed_q, stretch_q;
    logic [15:0]        top_q, jumps_q, s_peak_q, s_limit_q;
    logic [31:0]        pt_time_q, armed_at_q, s_start_q;
    logic signed [31:0] pt_x_q, pt_z_q, s_x_q, s_z_q;

    t_out_item expected_results[$];

    function automatic void clear_trip_state();
        top_q = '0; pt_known_q = 1'b0; pt_time_q = '0; pt_x_q = '0; pt_z_q = '0;
        jumps_q = '0; armed_q = 1'b0; armed_at_q = '0; stretch_q = 1'b0;
        s_start_q = '0; s_peak_q = '0; s_limit_q = '0; s_x_q = '0; s_z_q = '0;
    endfunction

    // Works out the result of one sample and advances the local state.
    function automatic t_out_item supervise_sample(t_in_item s);
        t_out_item    r;
        logic         taken, closed, over;
        longint       dt, dx, dz;
        logic [127:0] ax, az, d2, dmin, lhs, rhs, udt, spd;
        taken  = 1'b0;
        closed = 1'b0;
        if (s.trip_active && !trip_on_q) clear_trip_state();
        trip_on_q = s.trip_active;
        if (s.trip_active) begin
            dt = longint'({32'b0, s.wall_seconds}) - longint'({32'b0, pt_time_q});
            if (s.speed > top_q) top_q = s.speed;

            // Route point, with the squared jump test against the last point.
            if (s.position_known && (!pt_known_q || dt >= longint'(interval_q))) begin
                if (pt_known_q && dt > 0) begin
                    dx   = longint'(s.pos_x) - longint'(pt_x_q);
                    dz   = longint'(s.pos_z) - longint'(pt_z_q);
                    ax   = (dx < 0) ? 128'(-dx) : 128'(dx);
                    az   = (dz < 0) ? 128'(-dz) : 128'(dz);
                    d2   = ax * ax + az * az;
                    dmin = 128'(jump_min_q) * 128'(jump_min_q);
                    if (d2 > dmin) begin
                        udt = 128'(dt);
                        spd = 128'(jump_spd_q);
                        rhs = udt * udt * spd * spd * 128'd4;
                        lhs = d2 * 128'(JUMP_K);
                        if (lhs > rhs && jumps_q != 16'hFFFF) jumps_q = jumps_q + 16'd1;
                    end
                end
                pt_time_q  = s.wall_seconds;
                pt_x_q     = s.pos_x;
                pt_z_q     = s.pos_z;
                pt_known_q = 1'b1;
                taken      = 1'b1;
            end

            // Overspeed timing and the speeding stretch.
            over = (s.speed_limit != 0) &&
                   (32'(s.speed) > 32'(s.speed_limit) + 32'(margin_q));
            if (over) begin
                if (!armed_q) begin
                    armed_q    = 1'b1;
                    armed_at_q = s.steady_ms;
                end
                if (!stretch_q && (s.steady_ms - armed_at_q) >= 32'(min_over_q)) begin
                    stretch_q = 1'b1;
                    s_start_q = s.wall_seconds;
                    s_peak_q  = s.speed;
                    s_limit_q = s.speed_limit;
                    s_x_q     = s.position_known ? s.pos_x : '0;
                    s_z_q     = s.position_known ? s.pos_z : '0;
                end
                if (stretch_q && s.speed > s_peak_q) s_peak_q = s.speed;
            end else begin
                armed_q = 1'b0;
                if (stretch_q) begin
                    stretch_q = 1'b0;
                    closed    = 1'b1;
                end
            end
        end
        r.top_speed       = top_q;
        r.jump_count      = jumps_q;
        r.speeding_active = stretch_q;
        r.point_taken     = taken;
        r.stretch_closed  = closed;
        r.stretch_peak    = s_peak_q;
        r.stretch_limit   = s_limit_q;
        r.stretch_start   = s_start_q;
        r.stretch_end     = closed ? s.wall_seconds : '0;
        r.stretch_x       = s_x_q;
        r.stretch_z       = s_z_q;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
            o_errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            margin_q   = RST_SPEED_MARGIN;
            min_over_q = RST_MIN_OVER_MS;
            interval_q = RST_ROUTE_INT;
            jump_min_q = RST_JUMP_MIN;
            jump_spd_q = RST_JUMP_MAXSPD;
            trip_on_q  = 1'b0;
            clear_trip_state();
            expected_results.delete();
        end else begin
            // Register writes.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SPEED_MARGIN: margin_q   = i_cfg_data[15:0];
                    REG_MIN_OVER_MS:  min_over_q = i_cfg_data[19:0];
                    REG_ROUTE_INT:    interval_q = i_cfg_data[11:0];
                    REG_JUMP_MIN:     jump_min_q = i_cfg_data[19:0];
                    REG_JUMP_MAXSPD:  jump_spd_q = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            // Accepted input items.
            if (i_in_valid && i_in_ready)
                expected_results = {expected_results, supervise_sample(i_in_item)};
            // Accepted result items.
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result item with no expected result waiting");
                    o_errors++;
                end else begin
                    e = expected_results.pop_front();
                    check_field("top_speed", 32'(e.top_speed), 32'(i_out_item.top_speed));
                    check_field("jump_count", 32'(e.jump_count), 32'(i_out_item.jump_count));
                    check_field("speeding_active", 32'(e.speeding_active),
                                32'(i_out_item.speeding_active));
                    check_field("point_taken", 32'(e.point_taken),
                                32'(i_out_item.point_taken));
                    check_field("stretch_closed", 32'(e.stretch_closed),
                                32'(i_out_item.stretch_closed));
                    check_field("stretch_peak", 32'(e.stretch_peak),
                                32'(i_out_item.stretch_peak));
                    check_field("stretch_limit", 32'(e.stretch_limit),
                                32'(i_out_item.stretch_limit));
                    check_field("stretch_start", e.stretch_start, i_out_item.stretch_start);
                    check_field("stretch_end", e.stretch_end, i_out_item.stretch_end);
                    check_field("stretch_x", e.stretch_x, i_out_item.stretch_x);
                    check_field("stretch_z", e.stretch_z, i_out_item.stretch_z);
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

FILE: verif/trip_speeding_monitor_tb.sv
// ----------------------------------------------------------------------------
// trip_speeding_monitor_tb: stimulus and verdict for the trip supervisor.
// Drives directed samples and random trips through several register settings
// with random gaps and stalls on both channels; the checker does the scoring.
// ----------------------------------------------------------------------------
module trip_speeding_monitor_tb;
    import tsm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 80;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    t_in_item            i_in_item = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out_item           o_out_item;
    logic                i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;

    int  fail_count, pending;
    int  cycles = 0;
    bit  no_gaps = 1'b0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;

    // Random trip generator state.
    logic [31:0]        g_wall, g_steady;
    logic signed [31:0] g_x, g_z;
    logic [15:0]        g_limit;
    logic               g_trip;

    always #4 i_clk = ~i_clk;

    trip_speeding_monitor i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_item(o_out_item),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    trip_speeding_monitor_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_in_item(i_in_item),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_out_item(o_out_item),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(fail_count), .o_pending(pending)
    );

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** trip_speeding_monitor: FAILED **");
            $finish;
        end
    end

    // Result receiver: random stalls, and one long hold-off on request.
    initial begin
        int n;
        forever begin
            if (hold_req && !hold_done) begin
                i_out_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_done = 1'b1;
            end
            n = no_gaps ? 0 : $urandom_range(0, 9);
            if (n > 0) begin
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // Offers one sample after a random gap and waits for its acceptance.
    task automatic send_sample(t_in_item s);
        int n;
        n = no_gaps ? 0 : $urandom_range(0, 9);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= s;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    function automatic t_in_item mk(logic [15:0] spd, logic [15:0] lim, logic pk,
                                    logic [31:0] x, logic [31:0] z, logic act,
                                    logic [31:0] wall, logic [31:0] steady);
        t_in_item s;
        s.speed = spd; s.speed_limit = lim; s.position_known = pk;
        s.pos_x = x; s.pos_z = z; s.trip_active = act;
        s.wall_seconds = wall; s.steady_ms = steady;
        return s;
    endfunction

    // Lets every expected result arrive and the block settle before a write.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Holds the write enable high; the caller drops it after the last write.
    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    task automatic set_regs(int mrg, int mo, int ri, int jm, int js);
        wait_idle();
        write_reg(REG_SPEED_MARGIN, CfgDataW'(mrg));
        write_reg(REG_MIN_OVER_MS, CfgDataW'(mo));
        write_reg(REG_ROUTE_INT, CfgDataW'(ri));
        write_reg(REG_JUMP_MIN, CfgDataW'(jm));
        write_reg(REG_JUMP_MAXSPD, CfgDataW'(js));
        i_cfg_we <= 1'b0;
    endtask

    // Random trips: mostly plausible driving with speeding, teleports, clock
    // steps backwards and trip restarts; a share of fully random noise.
    task automatic run_trips(int count, int pause_at);
        t_in_item s;
        int       k;
        for (int i = 0; i < count; i++) begin
            if (i == pause_at) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            k = $urandom_range(0, 99);
            if (k < 8) begin
                s = mk(16'($urandom), 16'($urandom), 1'($urandom), $urandom, $urandom,
                       1'($urandom), $urandom, $urandom);
            end else begin
                if ($urandom_range(0, 99) < 3) g_trip = ~g_trip;
                if ($urandom_range(0, 99) < 5) g_limit = 16'($urandom_range(3000, 13000));
                if ($urandom_range(0, 99) < 2) g_limit = 16'd0;
                if ($urandom_range(0, 99) < 3) begin
                    g_wall = g_wall - 32'($urandom_range(1, 50));
                end else begin
                    g_wall = g_wall + 32'($urandom_range(0, 4));
                end
                g_steady = g_steady + 32'($urandom_range(0, 2000));
                if ($urandom_range(0, 99) < 4) begin
                    g_x = $urandom;
                    g_z = $urandom;
                end else begin
                    g_x = g_x + 32'($urandom_range(0, 4000)) - 32'd2000;
                    g_z = g_z + 32'($urandom_range(0, 4000)) - 32'd2000;
                end
                s = mk(16'(32'(g_limit) + $urandom_range(0, 2500)), g_limit,
                       $urandom_range(0, 99) < 85, g_x, g_z, g_trip, g_wall, g_steady);
                if ($urandom_range(0, 99) < 20) s.speed = 16'($urandom_range(0, 4000));
            end
            send_sample(s);
        end
    endtask

    initial begin
        g_wall   = $urandom;
        g_steady = $urandom;
        g_x      = $urandom;
        g_z      = $urandom;
        g_limit  = 16'd8000;
        g_trip   = 1'b1;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed samples at the reset settings.
        send_sample(mk(16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0,
                       32'hFFFFFFFF, 32'hFFFFFFFF));
        send_sample(mk(16'd0, 16'd0, 1'b1, 32'h80000000, 32'h7FFFFFFF, 1'b1,
                       32'd100, 32'd0));
        send_sample(mk(16'hFFFF, 16'hFFFF, 1'b1, 32'h80000000, 32'h7FFFFFFF, 1'b1,
                       32'd102, 32'd500));
        // Jump across the full coordinate range.
        send_sample(mk(16'd1000, 16'd0, 1'b1, 32'h7FFFFFFF, 32'h80000000, 1'b1,
                       32'd105, 32'd900));
        // Clock going backwards: no point, no jump.
        send_sample(mk(16'd1000, 16'd5000, 1'b1, 32'd0, 32'd0, 1'b1, 32'd90, 32'd1000));
        // Overspeed timer armed just below the wrap of the ms counter.
        send_sample(mk(16'd6000, 16'd5000, 1'b0, 32'd5, 32'd6, 1'b1, 32'd110,
                       32'hFFFFFF00));
        send_sample(mk(16'd6200, 16'd5000, 1'b0, 32'd5, 32'd6, 1'b1, 32'd111,
                       32'h00000100));
        send_sample(mk(16'd6500, 16'd5000, 1'b1, 32'h12345678, 32'hEDCBA987, 1'b1,
                       32'd113, 32'h00000C00));
        send_sample(mk(16'd7000, 16'd5000, 1'b1, 32'h12345678, 32'hEDCBA987, 1'b1,
                       32'd114, 32'h00000D00));
        send_sample(mk(16'd5500, 16'd5000, 1'b1, 32'h12345678, 32'hEDCBA987, 1'b1,
                       32'd120, 32'h00000E00));
        // Second stretch qualified with an unknown position, left open at trip end.
        send_sample(mk(16'd9000, 16'd5000, 1'b0, 32'd1, 32'd1, 1'b1, 32'd121, 32'd5000));
        send_sample(mk(16'd9000, 16'd5000, 1'b0, 32'd1, 32'd1, 1'b1, 32'd122, 32'd9000));
        send_sample(mk(16'd100, 16'd5000, 1'b1, 32'd1, 32'd1, 1'b0, 32'd123, 32'd9100));
        // Rising trip flag clears everything.
        send_sample(mk(16'd100, 16'd5000, 1'b1, 32'd1, 32'd1, 1'b1, 32'd124, 32'd9200));
        send_sample(mk(16'd100, 16'd5000, 1'b1, 32'd1, 32'd1, 1'b1, 32'hFFFFFFFF, 32'd9300));
        run_trips(280, -1);

        // All registers at zero.
        set_regs(0, 0, 0, 0, 0);
        run_trips(300, 150);

        // Registers at high values; margin, jump distance and jump speed at their top values.
        set_regs(65535, 600000, 3600, 1048575, 65535);
        run_trips(250, -1);

        // Back-to-back stretch, then mid-range settings with a long hold-off.
        set_regs(300, 1500, 2, 800, 20000);
        no_gaps = 1'b1;
        run_trips(150, -1);
        no_gaps = 1'b0;
        hold_req = 1'b1;
        run_trips(250, -1);

        set_regs($urandom_range(0, 2000), $urandom_range(0, 8000), $urandom_range(0, 10),
                 $urandom_range(0, 5000), $urandom_range(1000, 40000));
        run_trips(270, -1);
        set_regs(1, 1, 1, 1, 1);
        run_trips(435, -1);

        // Drain and verdict.
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** trip_speeding_monitor: PASSED **");
        end else begin
            $display("** trip_speeding_monitor: FAILED **");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/tsm_pkg.sv
design/trip_speeding_monitor.sv
design/tsm_checker.sv
verif/trip_speeding_monitor_checker.sv
verif/trip_speeding_monitor_tb.sv
